### src/assert_macros.svh
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### src/i2c_trb_pkg.sv
package i2c_trb_pkg;

    // buffer depth in bytes (1 to 255)
    localparam int BUFFER_SIZE = 32;
    localparam int IDX_W       = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;
    localparam logic [7:0] BUF_SIZE_B = 8'(BUFFER_SIZE);

    // bus event codes
    typedef enum logic [2:0] {
        EV_WRITE_MATCH = 3'd0,
        EV_RX_ACK      = 3'd1,
        EV_RX_NACK     = 3'd2,
        EV_STOP        = 3'd3,
        EV_READ_MATCH  = 3'd4,
        EV_TX_ACK      = 3'd5,
        EV_TX_NACK     = 3'd6,
        EV_LAST        = 3'd7
    } t_event;

endpackage

### src/i2c_trb_if.sv
// Event channel: one bus event per item
interface i2c_trb_ev_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_req;
    logic [7:0] rx_byte;

    modport source (output valid, output event_req, output rx_byte, input ready);
    modport sink   (input valid, input event_req, input rx_byte, output ready);
endinterface

// Result channel: ack decision and transmit byte
interface i2c_trb_res_if;
    logic       valid;
    logic       ready;
    logic       ack_next;
    logic [7:0] tx_byte;
    logic       tx_valid;

    modport source (output valid, output ack_next, output tx_byte, output tx_valid,
                    input ready);
    modport sink   (input valid, input ack_next, input tx_byte, input tx_valid,
                    output ready);
endinterface

### src/i2c_target_register_buffer_top.sv
// Path: an accepted event passes the input register, then the result register,
// where the result is held until o_out.ready takes it.
// Throughput: one event per cycle while results are taken; the result register lets
// the next event in while a finished result waits.
// Reset (synchronous, active low): clears the pointer, the pointer-pending flag,
// all buffer bytes and both valid flags.
`include "assert_macros.svh"

module i2c_target_register_buffer_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    i2c_trb_ev_if.sink     i_in,
    i2c_trb_res_if.source  o_out
);

    // input register
    logic                 r_in_valid;
    i2c_trb_pkg::t_event  r_ev;
    logic [7:0]           r_rx;

    // block state
    logic                 r_pending;
    logic [7:0]           r_ptr;
    logic [7:0]           r_store [i2c_trb_pkg::BUFFER_SIZE];

    // result register
    logic                 r_out_valid;
    logic                 r_ack;
    logic [7:0]           r_txb;
    logic                 r_txv;

    // next values
    logic                 n_pending;
    logic [7:0]           n_ptr;
    logic                 n_ack;
    logic [7:0]           n_txb;
    logic                 n_txv;
    logic                 n_wr_en;

    logic                 advance;
    logic                 in_range;
    logic [7:0]           rd_byte;
    logic [7:0]           rx_ptr;

    // stage moves when the result slot is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;

    assign in_range = (r_ptr < i2c_trb_pkg::BUF_SIZE_B);
    assign rd_byte  = in_range ? r_store[r_ptr[i2c_trb_pkg::IDX_W-1:0]] : 8'd0;
    // pointer after a received byte
    assign rx_ptr   = r_pending ? r_rx : (r_ptr + 8'd1);

    // event decode
    always_comb begin
        n_pending = r_pending;
        n_ptr     = r_ptr;
        n_ack     = 1'b1;
        n_txb     = 8'd0;
        n_txv     = 1'b0;
        n_wr_en   = 1'b0;
        unique case (r_ev) inside
            i2c_trb_pkg::EV_WRITE_MATCH: begin
                n_pending = 1'b1;
            end
            i2c_trb_pkg::EV_RX_ACK, i2c_trb_pkg::EV_RX_NACK: begin
                n_pending = 1'b0;
                n_wr_en   = !r_pending && in_range;
                n_ptr     = rx_ptr;
                n_ack     = (rx_ptr != i2c_trb_pkg::BUF_SIZE_B);
                // nack past the end rewinds to the start
                if (r_ev == i2c_trb_pkg::EV_RX_NACK && rx_ptr > i2c_trb_pkg::BUF_SIZE_B) begin
                    n_ptr = 8'd0;
                    n_ack = 1'b1;
                end
            end
            i2c_trb_pkg::EV_READ_MATCH, i2c_trb_pkg::EV_TX_ACK: begin
                n_ack = (r_ptr != i2c_trb_pkg::BUF_SIZE_B);
                n_txb = rd_byte;
                n_txv = 1'b1;
                n_ptr = r_ptr + 8'd1;
            end
            default: begin
                n_ack = 1'b1;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_ev <= i2c_trb_pkg::t_event'(i_in.event_req);
            r_rx <= i_in.rx_byte;
        end
    end

    // pointer, flag and buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_ptr     <= 8'd0;
            for (int i = 0; i < i2c_trb_pkg::BUFFER_SIZE; i++) begin
                r_store[i] <= 8'd0;
            end
        end else if (advance) begin
            r_pending <= n_pending;
            r_ptr     <= n_ptr;
            if (n_wr_en) begin
                r_store[r_ptr[i2c_trb_pkg::IDX_W-1:0]] <= r_rx;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_ack <= n_ack;
            r_txb <= n_txb;
            r_txv <= n_txv;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.ack_next = r_ack;
    assign o_out.tx_byte  = r_txb;
    assign o_out.tx_valid = r_txv;

    // checks
    `ASSERT_SAME(a_txb_zero, r_out_valid && !r_txv, r_txb == 8'd0, "tx byte without transmit")
    `ASSERT_NEXT(a_wm_pending, advance && n_pending, r_pending, "pointer load not armed")
    `ASSERT_NEXT(a_ptr_hold, !advance, $stable(r_ptr) && $stable(r_pending), "state moved idle")
    `ASSERT_NEXT(a_tx_inc, advance && n_txv, r_ptr == $past(r_ptr) + 8'd1, "pointer not stepped")
    `ASSERT_NEXT(a_out_hold, r_out_valid && !o_out.ready, r_out_valid, "result dropped while stalled")

endmodule
